### hdl/henon_orbit_histogram_peaks_defines.svh
// Assertion macros shared by the Henon orbit histogram RTL.
// Expects the including module to have signals named clock and reset.
`ifndef HENON_ORBIT_HISTOGRAM_PEAKS_DEFINES_SVH
`define HENON_ORBIT_HISTOGRAM_PEAKS_DEFINES_SVH

// same-cycle implication
`define HOHP_ASSERT_NOW(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define HOHP_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### hdl/hohp_pkg.sv
// Shared constants, command/status types and helpers for the Henon histogram block.
// No dependencies.
`default_nettype none
package hohp_pkg;

   localparam int BIN_COUNT_DEF  = 256;
   localparam int COUNT_BITS_DEF = 16;
   localparam int ITER_BITS      = 16;
   localparam int PARAM_BITS     = 23;
   localparam int ORBIT_BITS     = 32;
   localparam int PEAK_BITS      = 16;

   localparam logic [ITER_BITS-1:0]         ITER_RESET = 16'd5000;
   localparam logic signed [ORBIT_BITS-1:0] START_Q24  = 32'sd3355443;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic upd;
   } dp_cmd_type;

   typedef struct packed {
      logic clear;
   } bin_cmd_type;

   typedef struct packed {
      logic busy;
   } bin_sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
      if (v > 45'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -45'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

### hdl/hohp_dp.sv
// Orbit datapath: Henon map step as x*x and b*x, then a*sq, then update.
// Depends on hohp_pkg.
`default_nettype none
module hohp_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hohp_pkg::dp_cmd_type   cmd,
   input  wire logic signed [22:0]     param_a,
   input  wire logic signed [22:0]     param_b,
   output logic signed [31:0]          orbit_x,
   output logic signed [31:0]          orbit_y,
   output logic                        step_valid
);

   logic signed [22:0] a_ff, b_ff;
   logic signed [31:0] x_ff, y_ff;
   logic signed [63:0] xx_ff;
   logic signed [54:0] bx_ff;
   logic signed [39:0] pl_ff;
   logic signed [46:0] ph_ff;
   logic               vld_ff;

   logic [38:0]        sq;
   logic signed [62:0] asq;
   logic signed [42:0] term;
   logic signed [44:0] nx_w;
   logic signed [44:0] ny_w;
   logic signed [31:0] x_in, y_in;

   always_comb begin
      sq   = xx_ff[62:24];
      asq  = (63'(ph_ff) <<< 16) + 63'(pl_ff);
      term = asq[62:20];                      // floor shift by 20
      nx_w = 45'(y_ff) + 45'sd16777216 - 45'(term);
      ny_w = 45'($signed(bx_ff[54:20]));
      x_in = hohp_pkg::sat32(nx_w);
      y_in = hohp_pkg::sat32(ny_w);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= param_a;
         b_ff <= param_b;
         x_ff <= hohp_pkg::START_Q24;
         y_ff <= hohp_pkg::START_Q24;
      end else if (cmd.upd) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (cmd.mul1) begin
         xx_ff <= x_ff * x_ff;
         bx_ff <= b_ff * x_ff;
      end
      if (cmd.mul2) begin
         // a * sq split in two partial products to keep each multiply narrow
         pl_ff <= a_ff * $signed({1'b0, sq[15:0]});
         ph_ff <= a_ff * $signed({1'b0, sq[38:16]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cmd.upd;
      end
   end

   assign orbit_x    = x_ff;
   assign orbit_y    = y_ff;
   assign step_valid = vld_ff;

endmodule
`default_nettype wire

### hdl/hohp_bin.sv
// Histogram binner: bin index pipeline, counter memory with clearing sweep, peak.
// Depends on hohp_pkg and the defines header.
`default_nettype none
`include "henon_orbit_histogram_peaks_defines.svh"
module hohp_bin #(
   parameter int BIN_COUNT  = hohp_pkg::BIN_COUNT_DEF,
   parameter int COUNT_BITS = hohp_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hohp_pkg::bin_cmd_type cmd,
   input  wire logic                  in_valid,
   input  wire logic signed [31:0]    in_value,
   output hohp_pkg::bin_sts_type      sts,
   output logic [15:0]                peak
);

   localparam int IW   = $clog2(BIN_COUNT);
   localparam int NUMW = 34 + ((IW > 8) ? IW : 8);
   localparam int HW   = NUMW - 26;
   localparam int QLIM = 45 * BIN_COUNT;
   localparam int QW   = $clog2(QLIM);
   localparam int K    = QW + 6;
   localparam int MW   = K - 5;
   localparam int PW   = QW + MW;
   localparam int MREC = (2 ** K + 44) / 45;
   localparam longint DIV_Q24 = 64'sd180 * 64'sd16777216;

   localparam logic signed [NUMW-1:0] CMUL  = NUMW'(BIN_COUNT - 180);
   localparam logic signed [NUMW-1:0] OFS   = NUMW'(64'(2 * BIN_COUNT) << 24);
   localparam logic signed [NUMW-1:0] NEG_D = NUMW'(-DIV_Q24);
   localparam logic [HW-1:0]          QLIM_V = HW'(QLIM);
   localparam logic [MW-1:0]          MREC_V = MW'(MREC);
   localparam logic [COUNT_BITS-1:0]  CMAX   = '1;

   logic [COUNT_BITS-1:0] mem_ff [BIN_COUNT];

   logic signed [NUMW-1:0] num_ff;
   logic [QW-1:0]          q_ff;
   logic [IW-1:0]          idx_ff, idx3_ff;
   logic [COUNT_BITS-1:0]  rd_ff;
   logic [COUNT_BITS-1:0]  pk_ff;
   logic [3:0]             stg_ff;
   logic                   clr_act_ff;
   logic [IW-1:0]          clr_cnt_ff;

   logic [HW-1:0]          qh;
   logic                   in_rng;
   logic [QW-1:0]          q_in;
   logic [PW-1:0]          prod;
   logic [COUNT_BITS-1:0]  cnt_in;
   logic [COUNT_BITS+15:0] pk_w;

   always_comb begin
      qh = num_ff[NUMW-1:26];
      // negative values still land in bin 0 while above minus one bin width
      if (num_ff[NUMW-1]) begin
         in_rng = (num_ff > NEG_D);
         q_in   = '0;
      end else begin
         in_rng = (qh < QLIM_V);
         q_in   = qh[QW-1:0];
      end
      prod   = PW'(q_ff) * PW'(MREC_V);    // divide by 45 via reciprocal
      cnt_in = (rd_ff == CMAX) ? rd_ff : rd_ff + 1'b1;
      pk_w   = {16'd0, pk_ff};
      peak   = (pk_w > (COUNT_BITS + 16)'(16'hFFFF)) ? 16'hFFFF : pk_w[15:0];
   end

   always_ff @(posedge clock) begin
      num_ff  <= NUMW'(in_value) * CMUL + OFS;
      q_ff    <= q_in;
      idx_ff  <= prod[K +: IW];
      idx3_ff <= idx_ff;
   end

   // counter memory: one write port (sweep or increment), one read port
   always_ff @(posedge clock) begin
      if (clr_act_ff) begin
         mem_ff[clr_cnt_ff] <= '0;
      end else if (stg_ff[3]) begin
         mem_ff[idx3_ff] <= cnt_in;
      end
      rd_ff <= mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff     <= '0;
         clr_act_ff <= 1'b0;
         clr_cnt_ff <= '0;
         pk_ff      <= '0;
      end else begin
         stg_ff <= {stg_ff[2], stg_ff[1], stg_ff[0] & in_rng, in_valid};
         if (cmd.clear) begin
            clr_act_ff <= 1'b1;
            clr_cnt_ff <= '0;
            pk_ff      <= '0;
         end else begin
            if (clr_act_ff) begin
               if (clr_cnt_ff == IW'(BIN_COUNT - 1)) begin
                  clr_act_ff <= 1'b0;
               end
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
            if (stg_ff[3] && (cnt_in > pk_ff)) begin
               pk_ff <= cnt_in;
            end
         end
      end
   end

   assign sts.busy = clr_act_ff | in_valid | (|stg_ff);

   `HOHP_ASSERT_NOW(a_clr_no_update, clr_act_ff, stg_ff == 4'd0, "bin update during clear")
   `HOHP_ASSERT_NEXT(a_peak_mono, !cmd.clear, pk_ff >= $past(pk_ff), "peak decreased")

endmodule
`default_nettype wire

### hdl/hohp_ctrl.sv
// Controller: item sequencing (clear, iterate, drain, result) and count register.
// Depends on hohp_pkg and the defines header.
`default_nettype none
`include "henon_orbit_histogram_peaks_defines.svh"
module hohp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [15:0]           csr_data,
   input  wire hohp_pkg::bin_sts_type sts,
   input  wire logic                  rsp_free,
   output hohp_pkg::dp_cmd_type       dp_cmd,
   output hohp_pkg::bin_cmd_type      bin_cmd,
   output logic                       rsp_load
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_MUL1  = 3'd2;
   localparam logic [2:0] S_MUL2  = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic [hohp_pkg::ITER_BITS-1:0] iter_ff;
   logic [hohp_pkg::ITER_BITS-1:0] itc_ff;
   logic                           accept;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_CLEAR;
         S_CLEAR: begin
            if (!sts.busy) state_in = (itc_ff == '0) ? S_FIN : S_MUL1;
         end
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_UPD;
         S_UPD:   state_in = (itc_ff == 16'd1) ? S_DRAIN : S_MUL1;
         S_DRAIN: if (!sts.busy) state_in = S_FIN;
         S_FIN:   if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd.load   = accept;
      dp_cmd.mul1   = (state_ff == S_MUL1);
      dp_cmd.mul2   = (state_ff == S_MUL2);
      dp_cmd.upd    = (state_ff == S_UPD);
      bin_cmd.clear = accept;
      rsp_load      = (state_ff == S_FIN) & rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= hohp_pkg::ITER_RESET;
         itc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            iter_ff <= csr_data;
         end
         if (accept) begin
            itc_ff <= iter_ff;
         end else if (state_ff == S_UPD) begin
            itc_ff <= itc_ff - 1'b1;
         end
      end
   end

   `HOHP_ASSERT_NOW(a_idle_quiet, state_ff == S_IDLE, !sts.busy, "binner busy while idle")
   `HOHP_ASSERT_NOW(a_upd_count, state_ff == S_UPD, itc_ff != '0, "step with no count left")
   `HOHP_ASSERT_NOW(a_fin_quiet, state_ff == S_FIN, !sts.busy, "result before drain")

endmodule
`default_nettype wire

### hdl/henon_orbit_histogram_peaks.sv
// Henon orbit histogram peaks, top level.
// One item at a time: clearing sweep, iteration_count map steps, drain, then result.
// A new item is not taken until the previous one has reached the output register.
// A new item is taken while the previous result waits in the output register.
// Synchronous active-high reset clears control; iteration_count resets to 5000.
`default_nettype none
module henon_orbit_histogram_peaks #(
   parameter int BIN_COUNT  = hohp_pkg::BIN_COUNT_DEF,
   parameter int COUNT_BITS = hohp_pkg::COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [22:0] param_a, [45:23] param_b, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] x_peak, [31:16] y_peak
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   hohp_pkg::dp_cmd_type  dp_cmd;
   hohp_pkg::bin_cmd_type bin_cmd;
   hohp_pkg::bin_sts_type sts, sts_x, sts_y;

   logic signed [31:0] orbit_x, orbit_y;
   logic               step_valid;
   logic [15:0]        x_peak, y_peak;
   logic               rsp_load, rsp_free;
   logic               rsp_tvalid_ff;
   logic [31:0]        rsp_tdata_ff;

   assign sts.busy = sts_x.busy | sts_y.busy;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   hohp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .sts        (sts),
      .rsp_free   (rsp_free),
      .dp_cmd     (dp_cmd),
      .bin_cmd    (bin_cmd),
      .rsp_load   (rsp_load)
   );

   hohp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .param_a    (req_tdata[22:0]),
      .param_b    (req_tdata[45:23]),
      .orbit_x    (orbit_x),
      .orbit_y    (orbit_y),
      .step_valid (step_valid)
   );

   hohp_bin #(.BIN_COUNT(BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_bin_x (
      .clock    (clock),
      .reset    (reset),
      .cmd      (bin_cmd),
      .in_valid (step_valid),
      .in_value (orbit_x),
      .sts      (sts_x),
      .peak     (x_peak)
   );

   hohp_bin #(.BIN_COUNT(BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_bin_y (
      .clock    (clock),
      .reset    (reset),
      .cmd      (bin_cmd),
      .in_valid (step_valid),
      .in_value (orbit_y),
      .sts      (sts_y),
      .peak     (y_peak)
   );

   // output register: holds a finished result until its transfer
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {y_peak, x_peak};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire
